>>> src/convex_polygon_overlap_sat_core_defines.svh
// ----------------------------------------------------------------------------
// Convex polygon overlap core: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_OVERLAP_SAT_CORE_DEFINES_SVH
`define CONVEX_POLYGON_OVERLAP_SAT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define CPOSAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define CPOSAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cposat_pkg.sv
// ----------------------------------------------------------------------------
// Convex polygon overlap core: package
// Default sizes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cposat_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned COORD_BITS_DEF   = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_AXIS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SUM,
    ST_CMP,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/convex_polygon_overlap_sat_core.sv
// ----------------------------------------------------------------------------
// Convex polygon overlap core
// Loads two convex polygons vertex by vertex and runs a separating axis test.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle while busy is low; a word with
// end_of_pair set is stored and then starts the test, and busy stays high
// until the result. The test runs on one multiplier under a sequencer: each
// projected vertex takes an x product, a y product, a sum and a min/max
// update, and each edge adds the steps of fetching its ends, forming the
// axis and checking the intervals. A gap or a zero-length edge ends the
// test before every edge is checked, and an overflow or an empty polygon
// ends it straight from the first state of the test. The result appears on
// overlap and status for exactly one cycle with done high and cannot be
// held off; the vertex stores are then emptied for the next pair.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_overlap_sat_core
  import cposat_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         poly_select,
  input  logic signed [COORD_BITS-1:0] vert_x,
  input  logic signed [COORD_BITS-1:0] vert_y,
  input  logic                         end_of_pair,
  output logic                         done,
  output logic                         overlap,
  output logic [1:0]                   status
);

  localparam int unsigned IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VTX_W  = 2 * COORD_BITS;
  localparam int unsigned AXIS_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * COORD_BITS + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;

  state_t state, state_next;

  logic [VTX_W-1:0] mem_first  [MAX_VERTICES];
  logic [VTX_W-1:0] mem_second [MAX_VERTICES];
  logic [VTX_W-1:0] rdata_first, rdata_second;
  logic             rsel_q;

  logic [CNT_W-1:0] count_first, count_second;
  logic             overflow_seen;

  logic             pass;       // 0: edges of first polygon, 1: of second
  logic             proj_sel;   // polygon being projected
  logic             first;      // next projection opens the interval
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] v_idx;

  logic signed [COORD_BITS-1:0] ea_x, ea_y;
  logic signed [AXIS_W-1:0]     axis_x, axis_y;
  logic signed [PROD_W-1:0]     prod_a, prod_b;
  logic signed [SUM_W-1:0]      proj;
  logic signed [SUM_W-1:0]      lo, hi, lo1, hi1;

  // combinational
  logic                         accept;
  logic                         full_first, full_second;
  logic                         any_empty;
  logic [IDX_W-1:0]             raddr;
  logic                         rsel;
  logic signed [COORD_BITS-1:0] vx, vy;
  logic [CNT_W-1:0]             n_edge, n_proj;
  logic [CNT_W-1:0]             a_inc, v_inc;
  logic                         a_last, v_last;
  logic [IDX_W-1:0]             b_idx;
  logic signed [AXIS_W-1:0]     axis_x_calc, axis_y_calc;
  logic                         axis_zero;
  logic signed [COORD_BITS-1:0] mul_v;
  logic signed [AXIS_W-1:0]     mul_axis;
  logic signed [PROD_W-1:0]     mul_out;
  logic signed [SUM_W-1:0]      lo_new, hi_new;
  logic                         gap;

  assign accept      = start && !busy;
  assign full_first  = (count_first == CNT_W'(MAX_VERTICES));
  assign full_second = (count_second == CNT_W'(MAX_VERTICES));
  assign any_empty   = (count_first == '0) || (count_second == '0);

  assign vx = rsel_q ? rdata_second[COORD_BITS-1:0] : rdata_first[COORD_BITS-1:0];
  assign vy = rsel_q ? rdata_second[VTX_W-1:COORD_BITS] : rdata_first[VTX_W-1:COORD_BITS];

  assign n_edge = pass ? count_second : count_first;
  assign n_proj = proj_sel ? count_second : count_first;
  assign a_inc  = CNT_W'(a_idx) + CNT_W'(1);
  assign v_inc  = CNT_W'(v_idx) + CNT_W'(1);
  assign a_last = (a_inc == n_edge);
  assign v_last = (v_inc == n_proj);
  assign b_idx  = a_last ? '0 : a_inc[IDX_W-1:0];

  // Axis is the edge normal, left unnormalized.
  assign axis_x_calc = AXIS_W'(ea_y) - AXIS_W'(vy);
  assign axis_y_calc = AXIS_W'(vx) - AXIS_W'(ea_x);
  assign axis_zero   = (axis_x_calc == '0) && (axis_y_calc == '0);

  // One multiplier serves both products of a projection.
  assign mul_v    = (state == ST_MUL_Y) ? vy : vx;
  assign mul_axis = (state == ST_MUL_Y) ? axis_y : axis_x;
  assign mul_out  = PROD_W'(mul_v) * PROD_W'(mul_axis);

  assign lo_new = (first || (proj < lo)) ? proj : lo;
  assign hi_new = (first || (proj > hi)) ? proj : hi;

  // Touching end points still count as overlap.
  assign gap = (hi < lo1) || (hi1 < lo);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && end_of_pair) state_next = ST_TEST;
      end
      ST_TEST: begin
        if (overflow_seen || any_empty) state_next = ST_DONE;
        else                            state_next = ST_EDGE_A;
      end
      ST_EDGE_A: state_next = ST_EDGE_B;
      ST_EDGE_B: state_next = ST_AXIS;
      ST_AXIS: begin
        if (axis_zero) state_next = ST_DONE;
        else           state_next = ST_MUL_X;
      end
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_SUM;
      ST_SUM:   state_next = ST_CMP;
      ST_CMP: begin
        if (!v_last || (proj_sel == pass)) state_next = ST_MUL_X;
        else                               state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (gap || (a_last && pass)) state_next = ST_DONE;
        else                         state_next = ST_EDGE_A;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and read port control
  always_comb begin
    busy  = (state != ST_IDLE);
    done  = (state == ST_DONE);
    raddr = v_idx;
    rsel  = proj_sel;
    case (state)
      ST_EDGE_A: begin
        raddr = a_idx;
        rsel  = pass;
      end
      ST_EDGE_B: begin
        raddr = b_idx;
        rsel  = pass;
      end
      ST_AXIS: begin
        raddr = '0;
        rsel  = pass;
      end
      ST_CMP: begin
        if (!v_last) begin
          raddr = v_inc[IDX_W-1:0];
        end else if (proj_sel == pass) begin
          raddr = '0;
          rsel  = ~pass;
        end
      end
      default: begin
        raddr = v_idx;
        rsel  = proj_sel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Vertex stores
  always_ff @(posedge clk) begin
    if (accept && !poly_select && !full_first) begin
      mem_first[count_first[IDX_W-1:0]] <= {vert_y, vert_x};
    end
    if (accept && poly_select && !full_second) begin
      mem_second[count_second[IDX_W-1:0]] <= {vert_y, vert_x};
    end
    rdata_first  <= mem_first[raddr];
    rdata_second <= mem_second[raddr];
    rsel_q       <= rsel;
  end

  // Counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count_first   <= '0;
      count_second  <= '0;
      overflow_seen <= 1'b0;
    end else if (state == ST_IDLE && accept) begin
      if (!poly_select) begin
        if (!full_first) count_first <= count_first + CNT_W'(1);
        else             overflow_seen <= 1'b1;
      end else begin
        if (!full_second) count_second <= count_second + CNT_W'(1);
        else              overflow_seen <= 1'b1;
      end
    end else if (state == ST_DONE) begin
      // drop both polygons once the result is out
      count_first   <= '0;
      count_second  <= '0;
      overflow_seen <= 1'b0;
    end
  end

  // Test datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_TEST: begin
        overlap <= 1'b0;
        pass    <= 1'b0;
        a_idx   <= '0;
        if (overflow_seen)  status <= STATUS_OVERFLOW;
        else if (any_empty) status <= STATUS_EMPTY;
        else                status <= STATUS_OK;
      end
      ST_EDGE_B: begin
        ea_x <= vx;
        ea_y <= vy;
      end
      ST_AXIS: begin
        axis_x   <= axis_x_calc;
        axis_y   <= axis_y_calc;
        v_idx    <= '0;
        proj_sel <= pass;
        first    <= 1'b1;
      end
      ST_MUL_X: prod_a <= mul_out;
      ST_MUL_Y: prod_b <= mul_out;
      ST_SUM:   proj   <= SUM_W'(prod_a) + SUM_W'(prod_b);
      ST_CMP: begin
        lo    <= lo_new;
        hi    <= hi_new;
        // reopen the interval when switching to the other polygon
        first <= v_last && (proj_sel == pass);
        if (!v_last) begin
          v_idx <= v_inc[IDX_W-1:0];
        end else if (proj_sel == pass) begin
          // hold the edge owner's interval, then project the other polygon
          lo1      <= lo_new;
          hi1      <= hi_new;
          proj_sel <= ~pass;
          v_idx    <= '0;
        end
      end
      ST_CHECK: begin
        if (gap) begin
          overlap <= 1'b0;
        end else if (a_last) begin
          if (pass) begin
            overlap <= 1'b1;
          end else begin
            pass  <= 1'b1;
            a_idx <= '0;
          end
        end else begin
          a_idx <= a_inc[IDX_W-1:0];
        end
      end
      default: begin
        pass <= pass;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/cposat_checker.sv
// ----------------------------------------------------------------------------
// Convex polygon overlap core: port checker
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "convex_polygon_overlap_sat_core_defines.svh"

module cposat_checker
  import cposat_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       end_of_pair,
  input logic       done,
  input logic       overlap,
  input logic [1:0] status
);

  `CPOSAT_ASSERT_NOW(a_no_overlap_on_error, clk, rst, done && (status != STATUS_OK), !overlap, "overlap reported with error status")
  `CPOSAT_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result word not a single strobe")
  `CPOSAT_ASSERT_NEXT(a_pair_starts_test, clk, rst, start && !busy && end_of_pair, busy && !done, "end of pair did not start a test")
  `CPOSAT_ASSERT_NEXT(a_vertex_load_idle, clk, rst, start && !busy && !end_of_pair, !busy && !done, "plain vertex word left the core busy")

endmodule

bind convex_polygon_overlap_sat_core cposat_checker u_cposat_checker (.*);

`default_nettype wire

>>> tb/cposat_overlap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon overlap core: result checker
// Watches the vertex and result channels of the core, keeps its own copy of
// both vertex stores, works out the verdict of every pair on the closing word
// and compares each result strobe with the oldest verdict still due.
// ----------------------------------------------------------------------------
module cposat_overlap_checker
  import cposat_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             poly_select,
  input  logic signed [COORD_BITS_DEF-1:0] vert_x,
  input  logic signed [COORD_BITS_DEF-1:0] vert_y,
  input  logic                             end_of_pair,
  input  logic                             done,
  input  logic                             overlap,
  input  logic [1:0]                       status,
  output int unsigned                      mismatches,
  output int unsigned                      pending
);

  typedef struct {
    logic signed [COORD_BITS_DEF-1:0] x;
    logic signed [COORD_BITS_DEF-1:0] y;
  } vertex_t;

  typedef struct {
    logic    overlaps;
    status_t code;
  } verdict_t;

  vertex_t     poly_a [MAX_VERTICES_DEF];
  vertex_t     poly_b [MAX_VERTICES_DEF];
  int unsigned count_a;
  int unsigned count_b;
  bit          dropped_vertex;
  verdict_t    verdicts_due [$];
  int unsigned bad_fields;

  initial begin
    mismatches = 0;
    pending    = 0;
    count_a    = 0;
    count_b    = 0;
    bad_fields = 0;
    dropped_vertex = 1'b0;
  end

  // Min and max of one polygon projected onto an unnormalized axis.
  function automatic void project_span(input bit which, input longint ax, input longint ay,
                                       output longint lo, output longint hi);
    int unsigned n;
    vertex_t     v;
    longint      q;
    n  = which ? count_b : count_a;
    lo = 0;
    hi = 0;
    for (int unsigned i = 0; i < n; i++) begin
      v = which ? poly_b[i] : poly_a[i];
      q = longint'($signed(v.x)) * ax + longint'($signed(v.y)) * ay;
      if (i == 0 || q < lo) lo = q;
      if (i == 0 || q > hi) hi = q;
    end
  endfunction

  // 1 when no edge normal of polygon 'own' separates the two polygons and none of its edges is degenerate.
  function automatic bit no_gap_on_edges(input bit own);
    int unsigned n, b;
    vertex_t     pa, pb;
    longint      ax, ay, lo_own, hi_own, lo_other, hi_other;
    n = own ? count_b : count_a;
    for (int unsigned a = 0; a < n; a++) begin
      b  = (a + 1 == n) ? 0 : a + 1;
      pa = own ? poly_b[a] : poly_a[a];
      pb = own ? poly_b[b] : poly_a[b];
      ax = -(longint'($signed(pb.y)) - longint'($signed(pa.y)));
      ay = longint'($signed(pb.x)) - longint'($signed(pa.x));
      // a degenerate edge gives no axis and ends the test as a miss
      if (ax == 0 && ay == 0) return 1'b0;
      project_span(own, ax, ay, lo_own, hi_own);
      project_span(!own, ax, ay, lo_other, hi_other);
      if (hi_other < lo_own || hi_own < lo_other) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t judge_pair();
    verdict_t v;
    v.overlaps = 1'b0;
    v.code     = STATUS_OK;
    if (dropped_vertex)
      v.code = STATUS_OVERFLOW;
    else if (count_a == 0 || count_b == 0)
      v.code = STATUS_EMPTY;
    else
      v.overlaps = no_gap_on_edges(1'b0) && no_gap_on_edges(1'b1);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      count_a = 0;
      count_b = 0;
      dropped_vertex = 1'b0;
      verdicts_due.delete();
    end else begin
      if (done === 1'b1) begin
        if (verdicts_due.size() == 0) begin
          bad_fields++;
          $display("%0t: result with nothing due: expected none, actual overlap %0b status %0d",
                   $time, overlap, status);
        end else begin
          want = verdicts_due.pop_front();
          if (overlap !== want.overlaps) begin
            bad_fields++;
            $display("%0t: overlap mismatch: expected %0b, actual %0b",
                     $time, want.overlaps, overlap);
          end
          if (status !== want.code) begin
            bad_fields++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.code, status);
          end
        end
      end
      if (start && !busy) begin
        // store the word first; a full store drops it and flags overflow
        if (!poly_select) begin
          if (count_a < MAX_VERTICES_DEF) begin
            poly_a[count_a].x = vert_x;
            poly_a[count_a].y = vert_y;
            count_a++;
          end else
            dropped_vertex = 1'b1;
        end else begin
          if (count_b < MAX_VERTICES_DEF) begin
            poly_b[count_b].x = vert_x;
            poly_b[count_b].y = vert_y;
            count_b++;
          end else
            dropped_vertex = 1'b1;
        end
        if (end_of_pair) begin
          verdicts_due.push_back(judge_pair());
          count_a = 0;
          count_b = 0;
          dropped_vertex = 1'b0;
        end
      end
    end
    mismatches <= bad_fields;
    pending    <= verdicts_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convex polygon overlap core: testbench
// Feeds vertex pairs to the core in random bursts: a few hand-built pairs
// first, then mostly regular convex pairs near each other, mixed with
// rectangles that touch, overlap or just miss, degenerate shapes, empty and
// overflowing polygons and raw noise. A checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb;
  import cposat_pkg::*;

  localparam int unsigned ITEM_TARGET = 1100;

  typedef struct {
    logic signed [COORD_BITS_DEF-1:0] x;
    logic signed [COORD_BITS_DEF-1:0] y;
  } point_t;

  logic                             clk;
  logic                             rst         = 1'b1;
  logic                             start       = 1'b0;
  logic                             poly_select = 1'b0;
  logic signed [COORD_BITS_DEF-1:0] vert_x      = '0;
  logic signed [COORD_BITS_DEF-1:0] vert_y      = '0;
  logic                             end_of_pair = 1'b0;
  logic                             busy;
  logic                             done;
  logic                             overlap;
  logic [1:0]                       status;
  int unsigned                      mismatches;
  int unsigned                      pending;

  point_t      shape_first  [$];
  point_t      shape_second [$];
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;

  convex_polygon_overlap_sat_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .poly_select(poly_select),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .end_of_pair(end_of_pair),
    .done       (done),
    .overlap    (overlap),
    .status     (status)
  );

  cposat_overlap_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .poly_select(poly_select),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .end_of_pair(end_of_pair),
    .done       (done),
    .overlap    (overlap),
    .status     (status),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [COORD_BITS_DEF-1:0] to_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[COORD_BITS_DEF-1:0];
  endfunction

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return MAX_VERTICES_DEF;
    if (r < 12) return $urandom_range(9, MAX_VERTICES_DEF - 1);
    return $urandom_range(3, 8);
  endfunction

  task automatic add_point(input bit which, input logic signed [COORD_BITS_DEF-1:0] x,
                           input logic signed [COORD_BITS_DEF-1:0] y);
    point_t p;
    p.x = x;
    p.y = y;
    if (which) shape_second.push_back(p);
    else shape_first.push_back(p);
  endtask

  task automatic add_noise(input bit which, input int n);
    for (int i = 0; i < n; i++)
      add_point(which, COORD_BITS_DEF'($urandom()), COORD_BITS_DEF'($urandom()));
  endtask

  // Vertices on a circle; small radii with many vertices give repeated points.
  task automatic add_ring(input bit which, input int n, input int cx, input int cy,
                          input int r);
    real phase, ang;
    phase = $urandom_range(0, 359) * 3.14159265 / 180.0;
    for (int k = 0; k < n; k++) begin
      ang = phase + 6.2831853 * k / n;
      add_point(which, to_coord(cx + $rtoi(r * $cos(ang))),
                to_coord(cy + $rtoi(r * $sin(ang))));
    end
  endtask

  task automatic add_rect(input bit which, input int x0, input int y0, input int w,
                          input int h);
    add_point(which, to_coord(x0), to_coord(y0));
    add_point(which, to_coord(x0 + w), to_coord(y0));
    add_point(which, to_coord(x0 + w), to_coord(y0 + h));
    add_point(which, to_coord(x0), to_coord(y0 + h));
  endtask

  // Hold start high until the word is taken; open a gap between bursts.
  task automatic send_word(input bit sel, input point_t p, input bit last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                              : $urandom_range(1, 12);
    end
    start       <= 1'b1;
    poly_select <= sel;
    vert_x      <= p.x;
    vert_y      <= p.y;
    end_of_pair <= last;
    do @(posedge clk); while (busy);
    burst_left--;
    words_sent++;
  endtask

  // Send both shapes, in either order or interleaved; the final word closes the pair.
  task automatic send_pair(input bit shuffle);
    int unsigned mode, i1, i2, total;
    bit          take_second;
    mode  = shuffle ? $urandom_range(0, 3) : 0;
    i1    = 0;
    i2    = 0;
    total = shape_first.size() + shape_second.size();
    for (int unsigned k = 0; k < total; k++) begin
      if (i1 == shape_first.size()) take_second = 1'b1;
      else if (i2 == shape_second.size()) take_second = 1'b0;
      else if (mode == 2) take_second = 1'b1;
      else if (mode == 3) take_second = 1'($urandom_range(0, 1));
      else take_second = 1'b0;
      if (take_second) begin
        send_word(1'b1, shape_second[i2], k == total - 1);
        i2++;
      end else begin
        send_word(1'b0, shape_first[i1], k == total - 1);
        i1++;
      end
    end
    shape_first.delete();
    shape_second.delete();
  endtask

  task automatic make_convex_pair();
    int scale, r1, r2, cx, cy;
    case ($urandom_range(0, 2))
      0:       scale = 40;
      1:       scale = 900;
      default: scale = 8000;
    endcase
    r1 = $urandom_range(scale / 4, scale);
    r2 = $urandom_range(scale / 4, scale);
    cx = spread(32000 - 4 * scale);
    cy = spread(32000 - 4 * scale);
    add_ring(1'b0, pick_size(), cx, cy, r1);
    add_ring(1'b1, pick_size(), cx + spread(r1 + r2 + 2), cy + spread(r1 + r2 + 2), r2);
  endtask

  // Rectangles that share an edge, overlap by one, or miss by one.
  task automatic make_rect_pair();
    int x0, y0, w, h, nudge;
    x0    = spread(20000);
    y0    = spread(20000);
    w     = $urandom_range(1, 2000);
    h     = $urandom_range(1, 2000);
    nudge = spread(1);
    add_rect(1'b0, x0, y0, w, h);
    if ($urandom_range(0, 1))
      add_rect(1'b1, x0 + w + nudge, y0 + spread(h), $urandom_range(1, 2000), h);
    else
      add_rect(1'b1, x0 + spread(w), y0 + h + nudge, w, $urandom_range(1, 2000));
  endtask

  task automatic make_degenerate_pair();
    int x0, y0;
    x0 = spread(30000);
    y0 = spread(30000);
    case ($urandom_range(0, 3))
      0: begin
        add_point(1'b0, to_coord(x0), to_coord(y0));
        add_point(1'b1, to_coord(x0 + spread(1)), to_coord(y0 + spread(1)));
      end
      1: begin
        // triangle with a repeated corner
        add_point(1'b0, to_coord(x0), to_coord(y0));
        add_point(1'b0, to_coord(x0 + 50), to_coord(y0));
        add_point(1'b0, to_coord(x0 + 50), to_coord(y0));
        add_point(1'b0, to_coord(x0), to_coord(y0 + 50));
        add_ring(1'b1, 3, x0 + 20, y0 + 20, 30);
      end
      2: begin
        // two crossing or parallel segments
        add_point(1'b0, to_coord(x0 - 100), to_coord(y0));
        add_point(1'b0, to_coord(x0 + 100), to_coord(y0));
        add_point(1'b1, to_coord(x0 + spread(120)), to_coord(y0 - 100));
        add_point(1'b1, to_coord(x0 + spread(120)), to_coord(y0 + spread(100)));
      end
      default: begin
        repeat ($urandom_range(2, 5)) add_point(1'b0, to_coord(x0), to_coord(y0));
        repeat ($urandom_range(1, 4)) add_point(1'b1, to_coord(x0), to_coord(y0));
      end
    endcase
  endtask

  initial begin
    int unsigned pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // second polygon only, then first polygon only
    add_point(1'b1, 16'sd5, -16'sd5);
    send_pair(1'b0);
    add_point(1'b0, -16'sd7, 16'sd9);
    send_pair(1'b0);
    // one vertex each: the single edge has zero length
    add_point(1'b0, 16'sd0, 16'sd0);
    add_point(1'b1, 16'sd0, 16'sd0);
    send_pair(1'b0);
    // squares sharing one side
    add_rect(1'b0, 0, 0, 10, 10);
    add_rect(1'b1, 10, 0, 10, 10);
    send_pair(1'b0);
    // corners of the coordinate range
    add_point(1'b0, 16'sh8000, 16'sh8000);
    add_point(1'b0, 16'sh7fff, 16'sh8000);
    add_point(1'b0, 16'sd0, 16'sh7fff);
    add_point(1'b1, 16'sh7fff, 16'sh7fff);
    add_point(1'b1, 16'sh8000, 16'sh7fff);
    add_point(1'b1, 16'sh7fff, 16'sd0);
    send_pair(1'b0);
    // far corners only: separated
    add_point(1'b0, 16'sh8000, 16'sh8000);
    add_point(1'b0, -16'sd32767, 16'sh8000);
    add_point(1'b0, 16'sh8000, -16'sd32767);
    add_point(1'b1, 16'sh7fff, 16'sh7fff);
    add_point(1'b1, 16'sd32766, 16'sh7fff);
    add_point(1'b1, 16'sh7fff, 16'sd32766);
    send_pair(1'b0);

    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) make_convex_pair();
      else if (pick < 72) make_rect_pair();
      else if (pick < 80) begin
        add_noise(1'b0, $urandom_range(1, 8));
        add_noise(1'b1, $urandom_range(1, 8));
      end else if (pick < 87) begin
        // overflow one store; the other may be empty
        pick = $urandom_range(0, 1);
        add_noise(pick[0], $urandom_range(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 4));
        add_noise(!pick[0], $urandom_range(0, 4));
      end else if (pick < 93) add_noise(1'($urandom_range(0, 1)), $urandom_range(1, 6));
      else make_degenerate_pair();
      send_pair(1'b1);
    end
    start <= 1'b0;

    // let the checker register the closing word before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("** convex_polygon_overlap_sat_core: PASSED **");
    else
      $display("** convex_polygon_overlap_sat_core: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** convex_polygon_overlap_sat_core: FAILED **");
    $finish;
  end

endmodule
